// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files of the retransmission tracker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("%m: assertion failed");
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/rt_pkg.sv -----
// Types and constants of the retransmission tracker.
// No dependencies; used by every module of the block.
package rt_pkg;

    localparam int OP_W       = 2;
    localparam int KIND_W     = 3;
    localparam int ID_W       = 31;
    localparam int TIME_W     = 32;
    localparam int IP_W       = 32;
    localparam int PORT_W     = 16;
    localparam int LEN_W      = 7;
    localparam int PEND_W     = 7;
    localparam int XMIT_W     = 32;
    localparam int SLOT_IDX_W = 6;
    localparam int TIMEOUT_W  = 16;

    localparam int IN_TDATA_W  = 120;
    localparam int OUT_TDATA_W = 136;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd2;
    localparam logic [APB_AW-1:0]    ADDR_TIMEOUT = 3'd0;

    localparam logic [OP_W-1:0] OP_SEND = 2'd0;
    localparam logic [OP_W-1:0] OP_ACK  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_SENT    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ACKED   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RETX    = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } rt_state_t;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [TIME_W-1:0] now_seconds;
        logic [ID_W-1:0]   ack_id;
        logic [IP_W-1:0]   dest_ip;
        logic [PORT_W-1:0] dest_udp_port;
        logic [LEN_W-1:0]  payload_len;
    } rt_in_t;

    typedef struct packed {
        logic [ID_W-1:0]   msg_id;
        logic [TIME_W-1:0] stamp;
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
        logic [LEN_W-1:0]  len;
    } rt_entry_t;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [ID_W-1:0]       message_id;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [IP_W-1:0]       out_dest_ip;
        logic [PORT_W-1:0]     out_dest_port;
        logic [LEN_W-1:0]      out_len;
        logic [PEND_W-1:0]     outstanding;
        logic [XMIT_W-1:0]     transmissions;
        logic                  last;
    } rt_result_t;

endpackage

// ----- rtl/retransmission_tracker.sv -----
// Each send, ack or tick scans the slot table through the table memory read port, one slot
// per cycle; a send stops at the lowest free slot, ack and tick walk every slot, and an ack or
// tick scan pauses while a result waits on a stalled output. One item is handled at a time.
// Reset: valid bits, counters, ids and timeout (2) clear at once; table contents stay
// undefined and need no clearing pass.
`include "assert_macros.svh"
module retransmission_tracker #(
    parameter int SLOTS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // now_seconds, ack_id, dest_ip, dest_udp_port, payload_len, zero pad
    input  logic [rt_pkg::IN_TDATA_W-1:0]       s_tdata,
    // opcode
    input  logic [rt_pkg::OP_W-1:0]             s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // message_id, slot_index, out_dest_ip, out_dest_port, out_len,
    // outstanding, transmissions, zero pad
    output logic [rt_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // kind
    output logic [rt_pkg::KIND_W-1:0]           m_tuser,
    output logic                                m_tlast,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rt_pkg::APB_AW-1:0]           paddr,
    input  logic [rt_pkg::APB_DW-1:0]           pwdata,
    output logic [rt_pkg::APB_DW-1:0]           prdata,
    output logic                                pready
);

    logic [rt_pkg::TIMEOUT_W-1:0] timeout_reg, timeout_next;
    logic                         out_vld_reg, out_vld_next;
    rt_pkg::rt_result_t           out_reg, out_next;

    rt_pkg::rt_in_t     in_data;
    logic               out_free;
    logic               push;
    rt_pkg::rt_result_t push_data;
    logic               cfg_hit;

    assign in_data.opcode        = s_tuser;
    assign in_data.now_seconds   = s_tdata[31:0];
    assign in_data.ack_id        = s_tdata[62:32];
    assign in_data.dest_ip       = s_tdata[94:63];
    assign in_data.dest_udp_port = s_tdata[110:95];
    assign in_data.payload_len   = s_tdata[117:111];

    rt_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (in_data),
        .timeout   (timeout_reg),
        .out_free  (out_free),
        .push      (push),
        .push_data (push_data)
    );

    // config register: word decode on paddr[2]
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == rt_pkg::ADDR_TIMEOUT[2]);
    assign prdata  = cfg_hit ? {16'b0, timeout_reg} : '0;

    always_comb
    begin
        timeout_next = timeout_reg;
        if (psel && penable && pwrite && cfg_hit)
        begin
            timeout_next = pwdata[rt_pkg::TIMEOUT_W-1:0];
        end
    end

    // output register
    assign out_free = !out_vld_reg || m_tready;

    always_comb
    begin
        out_vld_next = out_vld_reg;
        out_next     = out_reg;
        if (push)
        begin
            out_vld_next = 1'b1;
            out_next     = push_data;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= rt_pkg::TIMEOUT_RST;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            timeout_reg <= timeout_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {5'b0, out_reg.transmissions, out_reg.outstanding, out_reg.out_len,
                       out_reg.out_dest_port, out_reg.out_dest_ip, out_reg.slot_index,
                       out_reg.message_id};

    `ASSERT_IMPLIES(a_push_into_free, clk, rst_n, push, out_free)
    `ASSERT_IMPLIES(a_no_push_idle, clk, rst_n, s_tready, !push)
    `ASSERT_IMPLIES(a_outstanding_bound, clk, rst_n, m_tvalid,
                    out_reg.outstanding <= rt_pkg::PEND_W'(SLOTS))
    `ASSERT_IMPLIES(a_retx_counted, clk, rst_n,
                    push && (push_data.kind == rt_pkg::KIND_RETX),
                    push_data.transmissions != '0)

endmodule

// ----- rtl/rt_table.sv -----
// Slot table memory: id, time stamp, destination and length of each slot.
// One write port, one read port with registered read data; uses rt_pkg.
module rt_table #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output rt_pkg::rt_entry_t    rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  rt_pkg::rt_entry_t    wr_data
);

    rt_pkg::rt_entry_t mem [DEPTH];
    rt_pkg::rt_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/rt_ctrl.sv -----
// Scan sequencer: walks the slot table for send, ack and tick, keeps the
// valid bits and counters, and hands results out. Uses rt_pkg and rt_table.
module rt_ctrl #(
    parameter int SLOTS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  rt_pkg::rt_in_t                in_data,
    input  logic [rt_pkg::TIMEOUT_W-1:0]  timeout,
    input  logic                          out_free,
    output logic                          push,
    output rt_pkg::rt_result_t            push_data
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SLOTS);

    rt_pkg::rt_state_t state_reg, state_next;

    rt_pkg::rt_in_t   item_reg, item_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             eval_vld_reg, eval_vld_next;
    logic [SLOT_W-1:0] eval_idx_reg, eval_idx_next;
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [rt_pkg::ID_W-1:0]   next_id_reg, next_id_next;
    logic [rt_pkg::PEND_W-1:0] pending_reg, pending_next;
    logic [rt_pkg::XMIT_W-1:0] sent_reg, sent_next;
    logic               held_vld_reg, held_vld_next;
    rt_pkg::rt_result_t held_reg, held_next;

    logic              rd_en;
    logic              wr_en;
    rt_pkg::rt_entry_t rd_data;
    rt_pkg::rt_entry_t wr_data;

    logic                      scan_more;
    logic                      cur_valid;
    logic [rt_pkg::TIME_W-1:0] age;
    logic                      hit;
    logic                      stall;
    logic                      final_emit;
    logic [rt_pkg::XMIT_W-1:0] sent_inc;
    logic [rt_pkg::PEND_W-1:0] pend_dec;
    rt_pkg::rt_result_t        res;
    rt_pkg::rt_result_t        final_res;

    rt_table #(
        .DEPTH  (SLOTS),
        .ADDR_W (SLOT_W)
    ) u_table (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[SLOT_W-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (eval_idx_reg),
        .wr_data (wr_data)
    );

    assign scan_more = (rd_idx_reg != LAST_CNT);
    assign cur_valid = valid_reg[eval_idx_reg];
    assign age       = item_reg.now_seconds - rd_data.stamp;
    assign sent_inc  = (sent_reg == '1) ? sent_reg : sent_reg + 1'b1;
    assign pend_dec  = (pending_reg == '0) ? pending_reg : pending_reg - 1'b1;

    always_comb
    begin
        case (item_reg.opcode)
            rt_pkg::OP_SEND: hit = eval_vld_reg && !cur_valid;
            rt_pkg::OP_ACK:  hit = eval_vld_reg && cur_valid &&
                                   (rd_data.msg_id == item_reg.ack_id);
            rt_pkg::OP_TICK: hit = eval_vld_reg && cur_valid &&
                                   (age >= {16'b0, timeout});
            default:         hit = 1'b0;
        endcase
    end

    assign stall = (item_reg.opcode != rt_pkg::OP_SEND) && hit && held_vld_reg && !out_free;
    assign final_emit = held_vld_reg || (item_reg.opcode != rt_pkg::OP_TICK);

    // result of the slot under evaluation, counts taken after its update
    always_comb
    begin
        res               = '0;
        res.slot_index    = rt_pkg::SLOT_IDX_W'(eval_idx_reg);
        res.outstanding   = pending_reg;
        res.transmissions = sent_reg;
        case (item_reg.opcode)
            rt_pkg::OP_SEND:
            begin
                res.kind          = rt_pkg::KIND_SENT;
                res.message_id    = next_id_reg;
                res.outstanding   = pending_reg + 1'b1;
                res.transmissions = sent_inc;
            end
            rt_pkg::OP_ACK:
            begin
                res.kind        = rt_pkg::KIND_ACKED;
                res.message_id  = item_reg.ack_id;
                res.outstanding = pend_dec;
            end
            rt_pkg::OP_TICK:
            begin
                res.kind          = rt_pkg::KIND_RETX;
                res.message_id    = rd_data.msg_id;
                res.out_dest_ip   = rd_data.ip;
                res.out_dest_port = rd_data.port;
                res.out_len       = rd_data.len;
                res.transmissions = sent_inc;
            end
            default:
            begin
                res.kind = rt_pkg::KIND_UNKNOWN;
            end
        endcase
    end

    always_comb
    begin
        final_res               = '0;
        final_res.outstanding   = pending_reg;
        final_res.transmissions = sent_reg;
        if (held_vld_reg)
        begin
            final_res = held_reg;
        end
        else if (item_reg.opcode == rt_pkg::OP_SEND)
        begin
            final_res.kind = rt_pkg::KIND_FULL;
        end
        else
        begin
            final_res.kind       = rt_pkg::KIND_UNKNOWN;
            final_res.message_id = item_reg.ack_id;
        end
        final_res.last = 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rt_pkg::ST_IDLE:
            begin
                if (in_valid && (in_data.opcode != rt_pkg::OP_NOP))
                begin
                    state_next = rt_pkg::ST_SCAN;
                end
            end
            rt_pkg::ST_SCAN:
            begin
                if ((item_reg.opcode == rt_pkg::OP_SEND) && hit)
                begin
                    state_next = rt_pkg::ST_FLUSH;
                end
                else if (!stall && !scan_more)
                begin
                    state_next = rt_pkg::ST_FLUSH;
                end
            end
            rt_pkg::ST_FLUSH:
            begin
                if (!final_emit || out_free)
                begin
                    state_next = rt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        item_next     = item_reg;
        rd_idx_next   = rd_idx_reg;
        eval_vld_next = eval_vld_reg;
        eval_idx_next = eval_idx_reg;
        valid_next    = valid_reg;
        next_id_next  = next_id_reg;
        pending_next  = pending_reg;
        sent_next     = sent_reg;
        held_vld_next = held_vld_reg;
        held_next     = held_reg;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        wr_data       = rd_data;
        push          = 1'b0;
        push_data     = held_reg;
        case (state_reg)
            rt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next     = in_data;
                    rd_idx_next   = '0;
                    eval_vld_next = 1'b0;
                    held_vld_next = 1'b0;
                end
            end
            rt_pkg::ST_SCAN:
            begin
                if (!stall)
                begin
                    rd_en         = scan_more;
                    eval_vld_next = scan_more;
                    eval_idx_next = rd_idx_reg[SLOT_W-1:0];
                    rd_idx_next   = rd_idx_reg + CNT_W'(scan_more);
                    if (hit)
                    begin
                        held_next     = res;
                        held_vld_next = 1'b1;
                        push          = held_vld_reg;
                        push_data     = held_reg;
                        case (item_reg.opcode)
                            rt_pkg::OP_SEND:
                            begin
                                valid_next[eval_idx_reg] = 1'b1;
                                wr_en          = 1'b1;
                                wr_data.msg_id = next_id_reg;
                                wr_data.stamp  = item_reg.now_seconds;
                                wr_data.ip     = item_reg.dest_ip;
                                wr_data.port   = item_reg.dest_udp_port;
                                wr_data.len    = item_reg.payload_len;
                                next_id_next   = next_id_reg + 1'b1;
                                pending_next   = pending_reg + 1'b1;
                                sent_next      = sent_inc;
                            end
                            rt_pkg::OP_ACK:
                            begin
                                valid_next[eval_idx_reg] = 1'b0;
                                pending_next = pend_dec;
                            end
                            rt_pkg::OP_TICK:
                            begin
                                wr_en         = 1'b1;
                                wr_data.stamp = item_reg.now_seconds;
                                sent_next     = sent_inc;
                            end
                            default:
                            begin
                                held_vld_next = held_vld_reg;
                            end
                        endcase
                    end
                end
            end
            rt_pkg::ST_FLUSH:
            begin
                if (final_emit && out_free)
                begin
                    push          = 1'b1;
                    push_data     = final_res;
                    held_vld_next = 1'b0;
                end
            end
            default:
            begin
                held_vld_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rt_pkg::ST_IDLE;
            eval_vld_reg <= 1'b0;
            rd_idx_reg   <= '0;
            valid_reg    <= '0;
            next_id_reg  <= '0;
            pending_reg  <= '0;
            sent_reg     <= '0;
            held_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            eval_vld_reg <= eval_vld_next;
            rd_idx_reg   <= rd_idx_next;
            valid_reg    <= valid_next;
            next_id_reg  <= next_id_next;
            pending_reg  <= pending_next;
            sent_reg     <= sent_next;
            held_vld_reg <= held_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        eval_idx_reg <= eval_idx_next;
        held_reg     <= held_next;
    end

endmodule

// ----- test/tb_top.sv -----
// Stream and APB testbench for retransmission_tracker: queued stimulus, a shadow
// slot table that predicts every result, and a checker on the result stream.
// Depends on rt_pkg and the retransmission_tracker RTL.
module tb_top;

    localparam int NSLOT          = 64;
    localparam int SETTLE         = 80;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int IDLE_PCT       = 18;
    localparam int HOLD_AT        = 60;
    localparam int HOLD_CYCLES    = 600;
    localparam int CALM_FROM      = 180;
    localparam int CALM_TO        = 240;
    localparam int MAX_REPORTS    = 10;

    localparam int IN_PAD = rt_pkg::IN_TDATA_W - (rt_pkg::TIME_W + rt_pkg::ID_W +
                            rt_pkg::IP_W + rt_pkg::PORT_W + rt_pkg::LEN_W);
    localparam int O_ID   = 0;
    localparam int O_SLOT = O_ID + rt_pkg::ID_W;
    localparam int O_IP   = O_SLOT + rt_pkg::SLOT_IDX_W;
    localparam int O_PORT = O_IP + rt_pkg::IP_W;
    localparam int O_LEN  = O_PORT + rt_pkg::PORT_W;
    localparam int O_PEND = O_LEN + rt_pkg::LEN_W;
    localparam int O_XMIT = O_PEND + rt_pkg::PEND_W;

    // byte address of register index one, which does not exist
    localparam logic [rt_pkg::APB_AW-1:0] ADDR_SPARE = 3'd4;

    logic                            clk      = 1'b0;
    logic                            rst_n    = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [rt_pkg::IN_TDATA_W-1:0]   s_tdata  = '0;
    logic [rt_pkg::OP_W-1:0]         s_tuser  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [rt_pkg::OUT_TDATA_W-1:0]  m_tdata;
    logic [rt_pkg::KIND_W-1:0]       m_tuser;
    logic                            m_tlast;
    logic                            psel     = 1'b0;
    logic                            penable  = 1'b0;
    logic                            pwrite   = 1'b0;
    logic [rt_pkg::APB_AW-1:0]       paddr    = '0;
    logic [rt_pkg::APB_DW-1:0]       pwdata   = '0;
    logic [rt_pkg::APB_DW-1:0]       prdata;
    logic                            pready;

    retransmission_tracker #(
        .SLOTS (NSLOT)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 clk = ~clk;

    // shadow copy of the message table
    bit                          tab_valid [NSLOT];
    logic [rt_pkg::ID_W-1:0]     tab_id    [NSLOT];
    logic [rt_pkg::TIME_W-1:0]   tab_stamp [NSLOT];
    logic [rt_pkg::IP_W-1:0]     tab_ip    [NSLOT];
    logic [rt_pkg::PORT_W-1:0]   tab_port  [NSLOT];
    logic [rt_pkg::LEN_W-1:0]    tab_len   [NSLOT];
    logic [rt_pkg::ID_W-1:0]     id_next   = '0;
    logic [rt_pkg::PEND_W-1:0]   pend      = '0;
    logic [rt_pkg::XMIT_W-1:0]   xmit      = '0;
    logic [rt_pkg::TIMEOUT_W-1:0] timeout_s = rt_pkg::TIMEOUT_RST;

    rt_pkg::rt_in_t     op_q[$];
    rt_pkg::rt_in_t     on_wire;
    rt_pkg::rt_result_t owed[$];
    rt_pkg::rt_result_t seen;
    rt_pkg::rt_result_t want;

    int unsigned                inputs_done   = 0;
    int unsigned                items_offered = 0;
    int unsigned                faults        = 0;
    int unsigned                hold_left     = 0;
    bit                         hold_used     = 1'b0;
    int unsigned                stall_cycles  = 0;
    logic [rt_pkg::TIME_W-1:0]  clock_s       = '0;

    wire calm = (inputs_done >= CALM_FROM) && (inputs_done < CALM_TO);

    function automatic void owe(logic [rt_pkg::KIND_W-1:0] k, logic [rt_pkg::ID_W-1:0] id,
                                int slot, bit with_dest);
        rt_pkg::rt_result_t r;
        r = '0;
        r.kind = k;
        r.message_id = id;
        r.slot_index = slot[rt_pkg::SLOT_IDX_W-1:0];
        if (with_dest)
        begin
            r.out_dest_ip = tab_ip[slot];
            r.out_dest_port = tab_port[slot];
            r.out_len = tab_len[slot];
        end
        r.outstanding = pend;
        r.transmissions = xmit;
        owed.push_back(r);
    endfunction

    function automatic void bump_xmit();
        if (xmit != '1)
            xmit++;
    endfunction

    function automatic void track_item(rt_pkg::rt_in_t it);
        int n, i, free_slot;
        logic [rt_pkg::TIME_W-1:0] age;
        n = owed.size();
        free_slot = -1;
        case (it.opcode)
            rt_pkg::OP_SEND:
            begin
                for (i = 0; i < NSLOT; i++)
                    if (!tab_valid[i] && free_slot < 0)
                        free_slot = i;
                if (free_slot < 0)
                    owe(rt_pkg::KIND_FULL, '0, 0, 1'b0);
                else
                begin
                    tab_valid[free_slot] = 1'b1;
                    tab_id[free_slot] = id_next;
                    tab_stamp[free_slot] = it.now_seconds;
                    tab_ip[free_slot] = it.dest_ip;
                    tab_port[free_slot] = it.dest_udp_port;
                    tab_len[free_slot] = it.payload_len;
                    id_next++;
                    pend++;
                    bump_xmit();
                    owe(rt_pkg::KIND_SENT, tab_id[free_slot], free_slot, 1'b0);
                end
            end
            rt_pkg::OP_ACK:
            begin
                for (i = 0; i < NSLOT; i++)
                    if (tab_valid[i] && tab_id[i] == it.ack_id)
                    begin
                        tab_valid[i] = 1'b0;
                        if (pend != 0)
                            pend--;
                        owe(rt_pkg::KIND_ACKED, it.ack_id, i, 1'b0);
                    end
                if (owed.size() == n)
                    owe(rt_pkg::KIND_UNKNOWN, it.ack_id, 0, 1'b0);
            end
            rt_pkg::OP_TICK:
            begin
                for (i = 0; i < NSLOT; i++)
                begin
                    age = it.now_seconds - tab_stamp[i];
                    if (tab_valid[i] && age >= rt_pkg::TIME_W'(timeout_s))
                    begin
                        tab_stamp[i] = it.now_seconds;
                        bump_xmit();
                        owe(rt_pkg::KIND_RETX, tab_id[i], i, 1'b1);
                    end
                end
            end
            rt_pkg::OP_NOP: ;
            default: ;
        endcase
        if (owed.size() > n)
            owed[owed.size() - 1].last = 1'b1;
    endfunction

    function automatic string show(rt_pkg::rt_result_t r);
        return {$sformatf("kind=%0d id=%0d slot=%0d ip=%h port=%0d",
                          r.kind, r.message_id, r.slot_index, r.out_dest_ip, r.out_dest_port),
                $sformatf(" len=%0d pend=%0d xmit=%0d last=%0b",
                          r.out_len, r.outstanding, r.transmissions, r.last)};
    endfunction

    // mostly ids that are in flight, else stale, next or random ones
    function automatic logic [rt_pkg::ID_W-1:0] pick_ack();
        int s, j;
        s = $urandom_range(NSLOT - 1);
        if ($urandom_range(3) != 0)
            for (j = 0; j < NSLOT; j++)
                if (tab_valid[(s + j) % NSLOT])
                    return tab_id[(s + j) % NSLOT];
        if ($urandom_range(1) != 0)
            return id_next - rt_pkg::ID_W'($urandom_range(8));
        return rt_pkg::ID_W'($urandom);
    endfunction

    // input driver
    always @(negedge clk)
    begin
        if (rst_n && inputs_done == items_offered)
        begin
            if (op_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                on_wire = op_q.pop_front();
                items_offered++;
                s_tvalid <= 1'b1;
                s_tdata <= {IN_PAD'(0), on_wire.payload_len, on_wire.dest_udp_port,
                            on_wire.dest_ip, on_wire.ack_id, on_wire.now_seconds};
                s_tuser <= on_wire.opcode;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            track_item(on_wire);
            inputs_done++;
        end
    end

    // result-side ready, with one long hold-off
    always @(negedge clk)
    begin
        if (!hold_used && inputs_done >= HOLD_AT)
        begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen = '0;
            seen.kind = m_tuser;
            seen.message_id = m_tdata[O_ID +: rt_pkg::ID_W];
            seen.slot_index = m_tdata[O_SLOT +: rt_pkg::SLOT_IDX_W];
            seen.out_dest_ip = m_tdata[O_IP +: rt_pkg::IP_W];
            seen.out_dest_port = m_tdata[O_PORT +: rt_pkg::PORT_W];
            seen.out_len = m_tdata[O_LEN +: rt_pkg::LEN_W];
            seen.outstanding = m_tdata[O_PEND +: rt_pkg::PEND_W];
            seen.transmissions = m_tdata[O_XMIT +: rt_pkg::XMIT_W];
            seen.last = m_tlast;
            if (owed.size() == 0)
            begin
                faults++;
                if (faults <= MAX_REPORTS)
                    $display("unexpected result: %s", show(seen));
            end
            else
            begin
                want = owed.pop_front();
                if (seen !== want)
                begin
                    faults++;
                    if (faults <= MAX_REPORTS)
                        $display("result mismatch\n  expected %s\n  actual   %s",
                                 show(want), show(seen));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles == WATCHDOG_LIMIT)
        begin
            $display("[retransmission_tracker] ERROR");
            $finish;
        end
    end

    task automatic apb_write(logic [rt_pkg::APB_AW-1:0] addr, logic [rt_pkg::APB_DW-1:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == rt_pkg::ADDR_TIMEOUT)
            timeout_s = data[rt_pkg::TIMEOUT_W-1:0];
    endtask

    task automatic add_op(logic [rt_pkg::OP_W-1:0] op, logic [rt_pkg::TIME_W-1:0] now,
                          logic [rt_pkg::ID_W-1:0] ack, logic [rt_pkg::IP_W-1:0] ip,
                          logic [rt_pkg::PORT_W-1:0] port, logic [rt_pkg::LEN_W-1:0] len);
        rt_pkg::rt_in_t it;
        it.opcode = op;
        it.now_seconds = now;
        it.ack_id = ack;
        it.dest_ip = ip;
        it.dest_udp_port = port;
        it.payload_len = len;
        op_q.push_back(it);
    endtask

    task automatic settle();
        while (op_q.size() != 0 || inputs_done != items_offered || owed.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_mix(int count, int send_pct, int ack_pct, int tick_pct, int max_step);
        int k, roll;
        logic [rt_pkg::OP_W-1:0] op;
        for (k = 0; k < count; k++)
        begin
            // let the shadow table catch up so acks mostly hit live ids
            if (k % 16 == 0)
                while (op_q.size() != 0)
                    @(posedge clk);
            if ($urandom_range(39) == 0)
                clock_s = $urandom;
            else
                clock_s += rt_pkg::TIME_W'($urandom_range(max_step));
            roll = $urandom_range(99);
            if (roll < send_pct)
                op = rt_pkg::OP_SEND;
            else if (roll < send_pct + ack_pct)
                op = rt_pkg::OP_ACK;
            else if (roll < send_pct + ack_pct + tick_pct)
                op = rt_pkg::OP_TICK;
            else
                op = rt_pkg::OP_NOP;
            add_op(op, clock_s, pick_ack(), $urandom, rt_pkg::PORT_W'($urandom),
                   rt_pkg::LEN_W'($urandom_range(100)));
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, reset timeout of two seconds
        add_op(rt_pkg::OP_SEND, 32'd0, '0, '0, '0, '0);
        add_op(rt_pkg::OP_SEND, 32'd1, '1, '1, '1, 7'd100);
        add_op(rt_pkg::OP_TICK, 32'd1, rt_pkg::ID_W'($urandom), $urandom,
               rt_pkg::PORT_W'($urandom), 7'd0);
        add_op(rt_pkg::OP_TICK, 32'd2, rt_pkg::ID_W'($urandom), $urandom,
               rt_pkg::PORT_W'($urandom), 7'd64);
        add_op(rt_pkg::OP_NOP, '1, '1, '1, '1, 7'd100);
        add_op(rt_pkg::OP_ACK, $urandom, '0, $urandom, rt_pkg::PORT_W'($urandom), 7'd5);
        add_op(rt_pkg::OP_ACK, $urandom, '0, $urandom, rt_pkg::PORT_W'($urandom), 7'd5);
        add_op(rt_pkg::OP_ACK, $urandom, '1, $urandom, rt_pkg::PORT_W'($urandom), 7'd5);
        add_op(rt_pkg::OP_SEND, 32'hFFFF_FFF0, rt_pkg::ID_W'($urandom), $urandom,
               rt_pkg::PORT_W'($urandom), 7'd63);
        // time wrapped past zero: both live slots are old enough
        add_op(rt_pkg::OP_TICK, 32'd3, rt_pkg::ID_W'($urandom), $urandom,
               rt_pkg::PORT_W'($urandom), 7'd1);
        add_op(rt_pkg::OP_TICK, 32'd3, rt_pkg::ID_W'($urandom), $urandom,
               rt_pkg::PORT_W'($urandom), 7'd1);
        add_op(rt_pkg::OP_SEND, '1, rt_pkg::ID_W'($urandom), $urandom,
               rt_pkg::PORT_W'($urandom), 7'd99);
        add_op(rt_pkg::OP_ACK, 32'd4, 31'd1, $urandom, rt_pkg::PORT_W'($urandom), 7'd2);
        add_op(rt_pkg::OP_TICK, 32'h8000_0000, rt_pkg::ID_W'($urandom), $urandom,
               rt_pkg::PORT_W'($urandom), 7'd0);
        settle();

        // fill the table until sends bounce
        clock_s = 32'd1000;
        run_mix(110, 75, 8, 14, 2);
        settle();

        apb_write(ADDR_SPARE, $urandom);
        apb_write(rt_pkg::ADDR_TIMEOUT,
                  {(rt_pkg::APB_DW - rt_pkg::TIMEOUT_W)'($urandom), 16'h0000});
        run_mix(40, 25, 25, 40, 1);
        settle();

        apb_write(rt_pkg::ADDR_TIMEOUT,
                  {(rt_pkg::APB_DW - rt_pkg::TIMEOUT_W)'($urandom), 16'hFFFF});
        run_mix(40, 30, 30, 35, 40000);
        settle();

        apb_write(rt_pkg::ADDR_TIMEOUT, rt_pkg::APB_DW'(1));
        run_mix(40, 10, 60, 25, 1);
        run_mix(50, 35, 30, 30, 2);
        settle();

        apb_write(rt_pkg::ADDR_TIMEOUT, rt_pkg::APB_DW'($urandom_range(20, 3)));
        run_mix(30, 35, 30, 30, 4);
        settle();

        if (faults == 0 && owed.size() == 0)
            $display("[retransmission_tracker] OK");
        else
            $display("[retransmission_tracker] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/rt_pkg.sv
rtl/rt_table.sv
rtl/rt_ctrl.sv
rtl/retransmission_tracker.sv
test/tb_top.sv
